// File: rtl/core/dmwbc_pkg.sv
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared types, constants and the microcode table of the write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    localparam int NUM_LINES_DEF  = 16;
    localparam int LINE_BYTES_DEF = 16;
    localparam int MEM_BYTES_DEF  = 2048;
    localparam int ADDR_BITS      = 11;
    localparam int BYTE_BITS      = 8;
    localparam int STEP_BITS      = 3;

    typedef logic [STEP_BITS-1:0] step_t;

    // microprogram addresses
    localparam step_t STEP_INIT = 3'd0;
    localparam step_t STEP_IDLE = 3'd1;
    localparam step_t STEP_CMP  = 3'd2;
    localparam step_t STEP_DISP = 3'd3;
    localparam step_t STEP_WB   = 3'd4;
    localparam step_t STEP_FILL = 3'd5;
    localparam step_t STEP_ACC  = 3'd6;
    localparam step_t STEP_RES  = 3'd7;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ACCEPT,
        COND_HIT,
        COND_CLEAN,
        COND_LOOP_DONE,
        COND_INIT_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take_item;
        logic  tag_cmp;
        logic  wb_move;
        logic  fill_move;
        logic  init_fill;
        logic  line_access;
        logic  emit_result;
        logic  cnt_inc;
        logic  cnt_clear;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic accept;
        logic hit;
        logic clean;
        logic loop_done;
        logic init_done;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] byte_address;
        logic [BYTE_BITS-1:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_value;
        logic                 was_hit;
        logic                 wrote_back;
    } out_item_t;

    // Control word for each step. A true condition jumps to target; otherwise
    // hold stays on the step, else fall through to the next one.
    function automatic ctl_t ucode_rom(input step_t step);
        ctl_t w;
        w = '0;
        unique case (step)
            STEP_INIT: begin
                w.init_fill = 1'b1;
                w.cond      = COND_INIT_DONE;
                w.hold      = 1'b1;
                w.target    = STEP_IDLE;
            end
            STEP_IDLE: begin
                w.take_item = 1'b1;
                w.cond      = COND_ACCEPT;
                w.hold      = 1'b1;
                w.target    = STEP_CMP;
            end
            STEP_CMP: begin
                w.tag_cmp   = 1'b1;
                w.cnt_clear = 1'b1;
                w.cond      = COND_HIT;
                w.target    = STEP_ACC;
            end
            STEP_DISP: begin
                w.cnt_clear = 1'b1;
                w.cond      = COND_CLEAN;
                w.target    = STEP_FILL;
            end
            STEP_WB: begin
                w.wb_move = 1'b1;
                w.cnt_inc = 1'b1;
                w.cond    = COND_LOOP_DONE;
                w.hold    = 1'b1;
                w.target  = STEP_FILL;
            end
            STEP_FILL: begin
                w.fill_move = 1'b1;
                w.cnt_inc   = 1'b1;
                w.cond      = COND_LOOP_DONE;
                w.hold      = 1'b1;
                w.target    = STEP_ACC;
            end
            STEP_ACC: begin
                w.line_access = 1'b1;
                w.cond        = COND_NEVER;
                w.target      = STEP_RES;
            end
            STEP_RES: begin
                w.emit_result = 1'b1;
                w.cond        = COND_OUT_FREE;
                w.hold        = 1'b1;
                w.target      = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/direct_mapped_write_back_cache_core.sv
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core
// Direct-mapped write-allocate write-back byte cache with backing memory.
// ----------------------------------------------------------------------------
// After reset the block writes the backing memory with the low byte of each
// address and takes no transaction until that pass ends. A transaction then
// runs the tag compare and the line access on a hit; on a miss it first fills
// the line from the backing memory, copying a dirty line back before the fill.
// Line fills and write-backs are paced by the byte-wide ports of the line store
// and the backing memory, which move one byte per cycle. Results sit in an
// output register, so the next transaction is accepted as soon as the previous
// result is registered. NUM_LINES, LINE_BYTES and MEM_BYTES must be powers of
// two.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core #(
    parameter int NUM_LINES  = dmwbc_pkg::NUM_LINES_DEF,
    parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
    parameter int MEM_BYTES  = dmwbc_pkg::MEM_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmwbc_pkg::in_item_t   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmwbc_pkg::out_item_t  m_payload
);

    dmwbc_pkg::ctl_t      ctl;
    dmwbc_pkg::stat_t     stat;
    dmwbc_pkg::out_item_t result;

    logic                 m_valid_reg, m_valid_next;
    dmwbc_pkg::out_item_t m_payload_reg;
    logic                 out_free;
    logic                 emit;

    dmwbc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    dmwbc_dp #(
        .NUM_LINES  (NUM_LINES),
        .LINE_BYTES (LINE_BYTES),
        .MEM_BYTES  (MEM_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .s_valid   (s_valid),
        .s_payload (s_payload),
        .out_free  (out_free),
        .stat      (stat),
        .result    (result)
    );

    assign s_ready  = ctl.take_item;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = ctl.emit_result && out_free;

    always_comb begin
        priority if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // load the result once the output register is free
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("result transaction lost at output register");

    a_no_accept_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit_result |-> !s_ready)
        else $error("input accepted while result pending in sequencer");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.wrote_back) |-> !m_payload.was_hit)
        else $error("result reports both hit and write-back");

endmodule

// File: rtl/core/dmwbc_ram.sv
// ----------------------------------------------------------------------------
// dmwbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
    parameter int WIDTH = dmwbc_pkg::BYTE_BITS,
    parameter int DEPTH = dmwbc_pkg::NUM_LINES_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/dmwbc_seq.sv
// ----------------------------------------------------------------------------
// dmwbc_seq
// Microprogram sequencer: step counter, control table and jump logic.
// ----------------------------------------------------------------------------
module dmwbc_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  dmwbc_pkg::stat_t   stat,
    output dmwbc_pkg::ctl_t    ctl
);

    dmwbc_pkg::step_t step_reg;
    dmwbc_pkg::step_t step_next;
    logic             cond_true;

    assign ctl = dmwbc_pkg::ucode_rom(step_reg);

    always_comb begin
        unique case (ctl.cond)
            dmwbc_pkg::COND_NEVER:     cond_true = 1'b0;
            dmwbc_pkg::COND_ACCEPT:    cond_true = stat.accept;
            dmwbc_pkg::COND_HIT:       cond_true = stat.hit;
            dmwbc_pkg::COND_CLEAN:     cond_true = stat.clean;
            dmwbc_pkg::COND_LOOP_DONE: cond_true = stat.loop_done;
            dmwbc_pkg::COND_INIT_DONE: cond_true = stat.init_done;
            dmwbc_pkg::COND_OUT_FREE:  cond_true = stat.out_free;
            default:                   cond_true = 1'b0;
        endcase
    end

    always_comb begin
        priority if (cond_true) begin
            step_next = ctl.target;
        end else if (ctl.hold) begin
            step_next = step_reg;
        end else begin
            step_next = step_reg + dmwbc_pkg::step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= dmwbc_pkg::STEP_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/core/dmwbc_dp.sv
// ----------------------------------------------------------------------------
// dmwbc_dp
// Cache datapath: line state flops, tag, line and backing memories, the byte
// counter and the result fields, all driven by the current control word.
// ----------------------------------------------------------------------------
module dmwbc_dp #(
    parameter int NUM_LINES  = dmwbc_pkg::NUM_LINES_DEF,
    parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
    parameter int MEM_BYTES  = dmwbc_pkg::MEM_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dmwbc_pkg::ctl_t       ctl,
    input  logic                  s_valid,
    input  dmwbc_pkg::in_item_t   s_payload,
    input  logic                  out_free,
    output dmwbc_pkg::stat_t      stat,
    output dmwbc_pkg::out_item_t  result
);

    localparam int OB   = $clog2(LINE_BYTES);
    localparam int LB   = $clog2(NUM_LINES);
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int EAW  = (AW < dmwbc_pkg::ADDR_BITS) ? AW : dmwbc_pkg::ADDR_BITS;
    localparam int TW   = (EAW > OB + LB) ? EAW - OB - LB : 1;
    localparam int FW   = OB + LB + TW;
    localparam int LIW  = OB + LB;
    localparam int BW   = dmwbc_pkg::BYTE_BITS;

    // incoming address split
    logic [FW-1:0] s_xaddr;
    logic [LB-1:0] s_line;

    // latched transaction
    logic          action_reg;
    logic [OB-1:0] off_reg;
    logic [LB-1:0] line_reg;
    logic [TW-1:0] tag_reg;
    logic [BW-1:0] wbyte_reg;

    // lookup outcome
    logic          hit_reg, hit_next;
    logic          wb_reg, wb_next;
    logic [TW-1:0] vtag_reg;
    logic          hit_now;

    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [NUM_LINES-1:0] valid_reg, valid_next;
    logic [NUM_LINES-1:0] dirty_reg, dirty_next;

    logic [OB-1:0] off_cnt;
    logic [OB-1:0] off_prev;
    logic          cnt_nz;
    logic          accept;

    logic [TW-1:0]  tag_rdata;
    logic           tag_we;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [BW-1:0]  mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [BW-1:0]  mem_rdata;

    logic           line_we;
    logic [LIW-1:0] line_waddr;
    logic [BW-1:0]  line_wdata;
    logic [LIW-1:0] line_raddr;
    logic [BW-1:0]  line_rdata;

    assign s_xaddr = FW'(s_payload.byte_address[EAW-1:0]);
    assign s_line  = s_xaddr[OB+LB-1:OB];
    assign accept  = s_valid && ctl.take_item;

    assign off_cnt  = cnt_reg[OB-1:0];
    assign off_prev = off_cnt - OB'(1);
    assign cnt_nz   = (cnt_reg != '0);

    assign hit_now = valid_reg[line_reg] && (tag_rdata == tag_reg);

    assign stat.accept    = accept;
    assign stat.hit       = hit_now;
    assign stat.clean     = !wb_reg;
    assign stat.loop_done = (cnt_reg == AW'(LINE_BYTES));
    assign stat.init_done = (cnt_reg == AW'(MEM_BYTES - 1));
    assign stat.out_free  = out_free;

    // tag store: look up at accept, rewrite on a miss
    assign tag_we = ctl.line_access && !hit_reg;

    dmwbc_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (line_reg),
        .wr_data (tag_reg),
        .rd_addr (s_line),
        .rd_data (tag_rdata)
    );

    // backing memory: init pattern after reset, victim bytes during write-back
    assign mem_we    = ctl.init_fill || (ctl.wb_move && cnt_nz);
    assign mem_waddr = ctl.init_fill ? cnt_reg : AW'({vtag_reg, line_reg, off_prev});
    assign mem_wdata = ctl.init_fill ? cnt_reg[BW-1:0] : line_rdata;
    assign mem_raddr = AW'({tag_reg, line_reg, off_cnt});

    dmwbc_ram #(
        .WIDTH (BW),
        .DEPTH (MEM_BYTES)
    ) u_mem_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // line data: fill from memory, or store the write byte
    assign line_we    = (ctl.fill_move && cnt_nz) || (ctl.line_access && action_reg);
    assign line_waddr = ctl.fill_move ? {line_reg, off_prev} : {line_reg, off_reg};
    assign line_wdata = ctl.fill_move ? mem_rdata : wbyte_reg;
    assign line_raddr = ctl.wb_move ? {line_reg, off_cnt} : {line_reg, off_reg};

    dmwbc_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_LINES * LINE_BYTES)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (line_waddr),
        .wr_data (line_wdata),
        .rd_addr (line_raddr),
        .rd_data (line_rdata)
    );

    always_comb begin
        hit_next   = hit_reg;
        wb_next    = wb_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        if (ctl.tag_cmp) begin
            hit_next = hit_now;
            wb_next  = !hit_now && valid_reg[line_reg] && dirty_reg[line_reg];
        end
        if (ctl.line_access) begin
            valid_next[line_reg] = 1'b1;
            dirty_next[line_reg] = (hit_reg && dirty_reg[line_reg]) || action_reg;
        end
    end

    // init pass wraps at the top of memory; line loops restart when done
    always_comb begin
        priority if (ctl.init_fill) begin
            cnt_next = cnt_reg + AW'(1);
        end else if (ctl.cnt_inc) begin
            cnt_next = stat.loop_done ? '0 : cnt_reg + AW'(1);
        end else if (ctl.cnt_clear) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 1'b0;
            wb_reg    <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
        end else begin
            hit_reg   <= hit_next;
            wb_reg    <= wb_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_payload.action;
            off_reg    <= s_xaddr[OB-1:0];
            line_reg   <= s_line;
            tag_reg    <= s_xaddr[FW-1:OB+LB];
            wbyte_reg  <= s_payload.write_byte;
        end
        if (ctl.tag_cmp) begin
            vtag_reg <= tag_rdata;
        end
    end

    assign result.byte_value = action_reg ? wbyte_reg : line_rdata;
    assign result.was_hit    = hit_reg;
    assign result.wrote_back = wb_reg;

    a_wb_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_reg |-> !hit_reg)
        else $error("write-back flagged on a hit");

    a_no_line_write_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.init_fill |-> !line_we)
        else $error("line store written during memory init");

    a_accept_then_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ctl.tag_cmp)
        else $error("tag compare did not follow accepted transaction");

    a_fill_then_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fill_move && stat.loop_done) |=> ctl.line_access)
        else $error("line access did not follow completed fill");

endmodule

// File: sim/direct_mapped_write_back_cache_core_tb.sv
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core_tb
// Byte reads and writes go through the valid/ready input channel: first a
// directed table covering cold misses, hits, dirty and clean evictions and the
// address extremes, then random traffic weighted toward line conflicts and
// reuse. A behavioral copy of the cache and its backing memory predicts every
// result, and each result is compared field by field in order. Both channels
// stall at random except in the last of three random phases, which has none.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core_tb;

    import dmwbc_pkg::*;

    localparam int NUM_LINES   = NUM_LINES_DEF;
    localparam int LINE_BYTES  = LINE_BYTES_DEF;
    localparam int MEM_BYTES   = MEM_BYTES_DEF;
    localparam int OFS_W       = $clog2(LINE_BYTES);
    localparam int IDX_W       = $clog2(NUM_LINES);
    localparam int TAG_W       = ADDR_BITS - OFS_W - IDX_W;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_WAIT  = 60;
    localparam int STALL_LIMIT = 20000;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    localparam int DIR_N = 22;

    // {action, address, write byte, typed, byte_value, was_hit, wrote_back}
    dir_row_t dir_rows [DIR_N] = '{
        {ACT_READ,  11'h000, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
        {ACT_READ,  11'h7FF, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0},
        {ACT_READ,  11'h001, 8'h00, 1'b1, 8'h01, 1'b1, 1'b0},
        {ACT_WRITE, 11'h7FF, 8'hAB, 1'b1, 8'hAB, 1'b1, 1'b0},
        {ACT_READ,  11'h0FF, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b1},
        {ACT_READ,  11'h7FF, 8'h00, 1'b1, 8'hAB, 1'b0, 1'b0},
        {ACT_WRITE, 11'h000, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0},
        {ACT_WRITE, 11'h00F, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0},
        {ACT_READ,  11'h100, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1},
        {ACT_READ,  11'h00F, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0},
        {ACT_WRITE, 11'h555, 8'h5A, 1'b1, 8'h5A, 1'b0, 1'b0},
        {ACT_WRITE, 11'h2AA, 8'hA5, 1'b1, 8'hA5, 1'b0, 1'b0},
        {ACT_READ,  11'h555, 8'h00, 1'b1, 8'h5A, 1'b1, 1'b0},
        {ACT_WRITE, 11'h255, 8'h3C, 1'b1, 8'h3C, 1'b0, 1'b1},
        {ACT_READ,  11'h550, 8'h00, 1'b1, 8'h50, 1'b0, 1'b1},
        {ACT_READ,  11'h555, 8'h00, 1'b1, 8'h5A, 1'b1, 1'b0},
        {ACT_WRITE, 11'h6F0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        {ACT_READ,  11'h2A0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
        {ACT_WRITE, 11'h7F0, 8'h81, 1'b0, 8'h00, 1'b0, 1'b0},
        {ACT_READ,  11'h0F0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        {ACT_READ,  11'h3C3, 8'h7E, 1'b0, 8'h00, 1'b0, 1'b0},
        {ACT_WRITE, 11'h43C, 8'hC3, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    // shadow of the cache and its backing memory
    logic [BYTE_BITS-1:0] mem_image [MEM_BYTES];
    logic [BYTE_BITS-1:0] cl_data   [NUM_LINES*LINE_BYTES];
    logic [TAG_W-1:0]     cl_tag    [NUM_LINES];
    logic                 cl_valid  [NUM_LINES];
    logic                 cl_dirty  [NUM_LINES];

    out_item_t expected_results [$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_cycles;

    direct_mapped_write_back_cache_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #4 aclk = ~aclk;

    function automatic out_item_t cache_access(input in_item_t it);
        logic [OFS_W-1:0] ofs;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        out_item_t        res;
        ofs = it.byte_address[OFS_W-1:0];
        idx = it.byte_address[OFS_W +: IDX_W];
        tg  = it.byte_address[ADDR_BITS-1 -: TAG_W];
        res = '0;
        res.was_hit = cl_valid[idx] && (cl_tag[idx] == tg);
        if (!res.was_hit) begin
            if (cl_valid[idx] && cl_dirty[idx]) begin
                for (int b = 0; b < LINE_BYTES; b++)
                    mem_image[{cl_tag[idx], idx, OFS_W'(b)}] = cl_data[{idx, OFS_W'(b)}];
                res.wrote_back = 1'b1;
            end
            for (int b = 0; b < LINE_BYTES; b++)
                cl_data[{idx, OFS_W'(b)}] = mem_image[{tg, idx, OFS_W'(b)}];
            cl_valid[idx] = 1'b1;
            cl_dirty[idx] = 1'b0;
            cl_tag[idx]   = tg;
        end
        if (it.action == ACT_WRITE) begin
            cl_data[{idx, ofs}] = it.write_byte;
            cl_dirty[idx]       = 1'b1;
        end
        res.byte_value = cl_data[{idx, ofs}];
        return res;
    endfunction

    // Present one transaction and predict its result once it is accepted.
    task automatic send_access(input in_item_t it, input logic typed, input out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = cache_access(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        in_item_t             it;
        logic [ADDR_BITS-1:0] prev_addr;
        int                   pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        prev_addr     = '0;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick            = $urandom_range(99);
            it.action       = 1'($urandom_range(1));
            it.write_byte   = BYTE_BITS'($urandom_range(255));
            it.byte_address = ADDR_BITS'($urandom_range(MEM_BYTES - 1));
            if (pick < 40) begin
                // reuse the last line to get hits
                it.byte_address[ADDR_BITS-1:OFS_W] = prev_addr[ADDR_BITS-1:OFS_W];
            end else if (pick < 75) begin
                // crowd a few lines to force evictions
                it.byte_address[OFS_W +: IDX_W] = IDX_W'($urandom_range(3));
            end
            prev_addr = it.byte_address;
            send_access(it, 1'b0, '0);
        end
    endtask

    // result side: random backpressure and in-order checking
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: byte_value %02h", m_payload.byte_value);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_payload.byte_value !== want.byte_value) begin
                    $error("byte_value: expected %02h, actual %02h",
                           want.byte_value, m_payload.byte_value);
                    mismatches++;
                end
                if (m_payload.was_hit !== want.was_hit) begin
                    $error("was_hit: expected %0b, actual %0b", want.was_hit, m_payload.was_hit);
                    mismatches++;
                end
                if (m_payload.wrote_back !== want.wrote_back) begin
                    $error("wrote_back: expected %0b, actual %0b",
                           want.wrote_back, m_payload.wrote_back);
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        send_idle_pct = 35;
        recv_idle_pct = 52;
        for (int a = 0; a < MEM_BYTES; a++)
            mem_image[a] = a[BYTE_BITS-1:0];
        for (int a = 0; a < NUM_LINES * LINE_BYTES; a++)
            cl_data[a] = '0;
        for (int l = 0; l < NUM_LINES; l++) begin
            cl_tag[l]   = '0;
            cl_valid[l] = 1'b0;
            cl_dirty[l] = 1'b0;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_N; r++)
            send_access(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        random_phase(35, 52);
        random_phase(52, 35);
        random_phase(0, 0);
        s_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
